>>> rtl/rff_pkg.sv
// Shared types, constants and helpers for the relative permeability / fractional flow unit.
package rff_pkg;

  // One quotient bit per divider cell.
  localparam int unsigned DIV_STEPS = 32;
  // Registered stages ahead of the output register: front end (4), phase divider,
  // mobility/slope post-processing (5), fraction divider.
  localparam int unsigned PIPE_DEPTH = 9 + 2 * DIV_STEPS;
  localparam int unsigned LANES = 4;

  localparam logic [15:0] ONE_Q15      = 16'h8000;
  localparam logic [30:0] MAX31        = 31'h7FFF_FFFF;
  localparam logic [32:0] MAX31_W33    = 33'h0_7FFF_FFFF;
  localparam logic [32:0] MIN32_MAG_W33 = 33'h0_8000_0000;
  localparam logic [31:0] MIN32_MAG    = 32'h8000_0000;
  localparam logic [31:0] LIN_SLOPE_HI = 32'h0000_8000;

  typedef enum logic [2:0] {
    CFG_KR_MODEL   = 3'd0,
    CFG_WATER_RES  = 3'd1,
    CFG_GAS_RES    = 3'd2,
    CFG_WATER_VISC = 3'd3,
    CFG_GAS_VISC   = 3'd4
  } cfg_idx_e;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_ZERO_TOTAL = 2'd1;
  localparam logic [1:0] STATUS_SATURATED  = 2'd2;

  // Partial state of one restoring division as it moves down the cell row.
  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] lo;
    logic [31:0] quo;
    logic [63:0] den;
  } div_t;

  // Floor quotient plus round-half-up from the final remainder.
  function automatic logic [32:0] div_round(input div_t d);
    logic rnd;
    rnd = (d.rem >= (d.den - d.rem));
    return {1'b0, d.quo} + {32'd0, rnd};
  endfunction

endpackage

>>> rtl/rff_div_cell.sv
// One restoring-division cell: resolves one quotient bit per clock while en_i is high.
module rff_div_cell (
  input  logic         clk_i,
  input  logic         en_i,
  input  rff_pkg::div_t d_i,
  output rff_pkg::div_t d_o
);

  rff_pkg::div_t d_d, d_q;
  logic [63:0] trial;
  logic        ge;

  always_comb begin
    trial     = {d_i.rem[62:0], d_i.lo[31]};
    ge        = (trial >= d_i.den);
    d_d.rem   = ge ? (trial - d_i.den) : trial;
    d_d.lo    = {d_i.lo[30:0], 1'b0};
    d_d.quo   = {d_i.quo[30:0], ge};
    d_d.den   = d_i.den;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule

>>> rtl/relperm_fractional_flow_unit.sv
// Top level: two-phase relative permeability, mobilities and fractional flows.
// Stages from input accept to out_valid_o: 4 front-end stages, 32 phase
//   divider cells, 5 post stages, 32 fraction divider cells, output register.
// Throughput: one word per cycle; in_stall_o is registered and rises once the skid
//   entry behind the output register fills, which freezes the whole pipe.
// Reset (async, active low): valid bits cleared, linear model, zero residuals, unit mu.
module relperm_fractional_flow_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] water_sat_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [30:0] water_mobility_o,
  output logic [30:0] water_mobility_slope_o,
  output logic [30:0] gas_mobility_o,
  output logic signed [31:0] gas_mobility_slope_o,
  output logic [30:0] total_mobility_o,
  output logic signed [31:0] total_mobility_slope_o,
  output logic [15:0] water_fraction_o,
  output logic signed [31:0] water_fraction_slope_o,
  output logic [15:0] gas_fraction_o,
  output logic signed [31:0] gas_fraction_slope_o,
  output logic [1:0]  status_o
);

  // Quantities that ride alongside the fraction divider row.
  typedef struct packed {
    logic [30:0] lw;
    logic [30:0] dlw;
    logic [30:0] lg;
    logic [31:0] dlg;
    logic [30:0] lt;
    logic [31:0] dlt;
    logic        neg_w;
    logic        neg_g;
    logic        ovf_w;
    logic        ovf_g;
    logic        flag;
  } side_t;

  typedef struct packed {
    logic [30:0] lw;
    logic [30:0] dlw;
    logic [30:0] lg;
    logic [31:0] dlg;
    logic [30:0] lt;
    logic [31:0] dlt;
    logic [15:0] fw;
    logic [31:0] dfw;
    logic [15:0] fg;
    logic [31:0] dfg;
    logic [1:0]  status;
  } res_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic        kr_model_q;
  logic [14:0] water_res_q, gas_res_q;
  logic [23:0] water_visc_q, gas_visc_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kr_model_q   <= 1'b0;
      water_res_q  <= '0;
      gas_res_q    <= '0;
      water_visc_q <= 24'h01_0000;
      gas_visc_q   <= 24'h01_0000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        rff_pkg::CFG_KR_MODEL:   kr_model_q   <= cfg_data_i[0];
        rff_pkg::CFG_WATER_RES:  water_res_q  <= cfg_data_i[14:0];
        rff_pkg::CFG_GAS_RES:    gas_res_q    <= cfg_data_i[14:0];
        rff_pkg::CFG_WATER_VISC: water_visc_q <= cfg_data_i;
        rff_pkg::CFG_GAS_VISC:   gas_visc_q   <= cfg_data_i;
        default: ; // unknown index: dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. Everything moves together while the skid entry is free.
  // ---------------------------------------------------------------------------
  logic pipe_en;
  logic accept;
  logic [rff_pkg::PIPE_DEPTH-1:0] vld_q;
  logic skid_valid_q, out_valid_q;

  assign pipe_en    = !skid_valid_q;
  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[rff_pkg::PIPE_DEPTH-2:0], accept};
    end
  end

  // ---------------------------------------------------------------------------
  // S0: clamp saturation, per-phase excess and 1 - residual.
  // Lane 0 is water, lane 1 is gas.
  // ---------------------------------------------------------------------------
  logic [15:0] sw_c, sg_c;
  logic [15:0] s0_e_q    [2];
  logic [15:0] s0_den1_q [2];
  logic [23:0] s0_visc_q [2];
  logic [1:0]  s0_act_q;
  logic        s0_quad_q;

  assign sw_c = (water_sat_i > rff_pkg::ONE_Q15) ? rff_pkg::ONE_Q15 : water_sat_i;
  assign sg_c = rff_pkg::ONE_Q15 - sw_c;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s0_quad_q    <= kr_model_q;
      s0_act_q[0]  <= (sw_c > {1'b0, water_res_q});
      s0_act_q[1]  <= (sg_c > {1'b0, gas_res_q});
      s0_e_q[0]    <= sw_c - {1'b0, water_res_q};
      s0_e_q[1]    <= sg_c - {1'b0, gas_res_q};
      s0_den1_q[0] <= rff_pkg::ONE_Q15 - {1'b0, water_res_q};
      s0_den1_q[1] <= rff_pkg::ONE_Q15 - {1'b0, gas_res_q};
      // zero viscosity behaves as the smallest step
      s0_visc_q[0] <= (water_visc_q == '0) ? 24'd1 : water_visc_q;
      s0_visc_q[1] <= (gas_visc_q == '0) ? 24'd1 : gas_visc_q;
    end
  end

  // S1: (1-r)*mu and e^2
  logic [39:0] s1_p_q    [2];
  logic [31:0] s1_e2_q   [2];
  logic [15:0] s1_e_q    [2];
  logic [15:0] s1_den1_q [2];
  logic [1:0]  s1_act_q;
  logic        s1_quad_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_quad_q <= s0_quad_q;
      s1_act_q  <= s0_act_q;
      for (int p = 0; p < 2; p++) begin
        s1_p_q[p]    <= {24'd0, s0_den1_q[p]} * {16'd0, s0_visc_q[p]};
        s1_e2_q[p]   <= {16'd0, s0_e_q[p]} * {16'd0, s0_e_q[p]};
        s1_e_q[p]    <= s0_e_q[p];
        s1_den1_q[p] <= s0_den1_q[p];
      end
    end
  end

  // S2: full denominator and the two dividend high parts per phase.
  // Inactive phase (s <= r) gets zero dividends, which yields zero quotients.
  logic [55:0] s2_den_q     [2];
  logic [31:0] s2_mob_hi_q  [2];
  logic [31:0] s2_slp_hi_q  [2];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int p = 0; p < 2; p++) begin
        s2_den_q[p] <= s1_quad_q ? ({16'd0, s1_p_q[p]} * {40'd0, s1_den1_q[p]})
                                 : {16'd0, s1_p_q[p]};
        if (!s1_act_q[p]) begin
          s2_mob_hi_q[p] <= '0;
          s2_slp_hi_q[p] <= '0;
        end else if (s1_quad_q) begin
          s2_mob_hi_q[p] <= s1_e2_q[p];
          s2_slp_hi_q[p] <= {s1_e_q[p], 16'd0};
        end else begin
          s2_mob_hi_q[p] <= {16'd0, s1_e_q[p]};
          s2_slp_hi_q[p] <= rff_pkg::LIN_SLOPE_HI;
        end
      end
    end
  end

  // S3: divider setup. Lanes: 0 water mob, 1 water slope, 2 gas mob, 3 gas slope.
  rff_pkg::div_t s3_div_d [rff_pkg::LANES];
  rff_pkg::div_t s3_div_q [rff_pkg::LANES];
  logic [rff_pkg::LANES-1:0] s3_ovf_d, s3_ovf_q;

  always_comb begin
    for (int l = 0; l < rff_pkg::LANES; l++) begin
      s3_div_d[l].rem = (l % 2 == 0) ? {32'd0, s2_mob_hi_q[l/2]} : {32'd0, s2_slp_hi_q[l/2]};
      s3_div_d[l].lo  = '0;
      s3_div_d[l].quo = '0;
      s3_div_d[l].den = {8'd0, s2_den_q[l/2]};
      // quotient would need more than 32 bits: certainly saturated
      s3_ovf_d[l]     = (s3_div_d[l].rem >= s3_div_d[l].den);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s3_div_q <= s3_div_d;
      s3_ovf_q <= s3_ovf_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Phase divider row
  // ---------------------------------------------------------------------------
  rff_pkg::div_t pc [rff_pkg::LANES][rff_pkg::DIV_STEPS+1];
  logic [rff_pkg::LANES-1:0] pside_q [rff_pkg::DIV_STEPS];

  for (genvar l = 0; l < rff_pkg::LANES; l++) begin : g_plane
    assign pc[l][0] = s3_div_q[l];
    for (genvar k = 0; k < rff_pkg::DIV_STEPS; k++) begin : g_pcell
      rff_div_cell u_cell (
        .clk_i (clk_i),
        .en_i  (pipe_en),
        .d_i   (pc[l][k]),
        .d_o   (pc[l][k+1])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      pside_q[0] <= s3_ovf_q;
      for (int k = 1; k < rff_pkg::DIV_STEPS; k++) begin
        pside_q[k] <= pside_q[k-1];
      end
    end
  end

  // R1: round and saturate the phase quotients
  logic [32:0] pq [rff_pkg::LANES];
  logic [rff_pkg::LANES-1:0] psat;
  logic [31:0] dlg_mag_c;
  logic [30:0] r1_lw_q, r1_dlw_q, r1_lg_q;
  logic [31:0] r1_dlg_q;
  logic        r1_flag_q;

  always_comb begin
    for (int l = 0; l < rff_pkg::LANES; l++) begin
      pq[l] = rff_pkg::div_round(pc[l][rff_pkg::DIV_STEPS]);
    end
    psat[0] = pside_q[rff_pkg::DIV_STEPS-1][0] || (pq[0] > rff_pkg::MAX31_W33);
    psat[1] = pside_q[rff_pkg::DIV_STEPS-1][1] || (pq[1] > rff_pkg::MAX31_W33);
    psat[2] = pside_q[rff_pkg::DIV_STEPS-1][2] || (pq[2] > rff_pkg::MAX31_W33);
    // gas slope is negative, so it may reach -2^31
    psat[3] = pside_q[rff_pkg::DIV_STEPS-1][3] || (pq[3] > rff_pkg::MIN32_MAG_W33);
    dlg_mag_c = psat[3] ? rff_pkg::MIN32_MAG : pq[3][31:0];
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      r1_lw_q   <= psat[0] ? rff_pkg::MAX31 : pq[0][30:0];
      r1_dlw_q  <= psat[1] ? rff_pkg::MAX31 : pq[1][30:0];
      r1_lg_q   <= psat[2] ? rff_pkg::MAX31 : pq[2][30:0];
      r1_dlg_q  <= 32'd0 - dlg_mag_c;
      r1_flag_q <= |psat;
    end
  end

  // R2: total mobility and its slope
  logic [31:0] lt_sum;
  logic [32:0] dlt_sum;
  side_t       r2_q;

  assign lt_sum  = {1'b0, r1_lw_q} + {1'b0, r1_lg_q};
  assign dlt_sum = {2'b00, r1_dlw_q} + {r1_dlg_q[31], r1_dlg_q};

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      r2_q.lw    <= r1_lw_q;
      r2_q.dlw   <= r1_dlw_q;
      r2_q.lg    <= r1_lg_q;
      r2_q.dlg   <= r1_dlg_q;
      r2_q.lt    <= lt_sum[31] ? rff_pkg::MAX31 : lt_sum[30:0];
      r2_q.dlt   <= dlt_sum[31:0]; // always in range
      r2_q.neg_w <= 1'b0;
      r2_q.neg_g <= 1'b0;
      r2_q.ovf_w <= 1'b0;
      r2_q.ovf_g <= 1'b0;
      r2_q.flag  <= r1_flag_q || lt_sum[31];
    end
  end

  // R3: quotient-rule products and lt^2
  logic signed [32:0] m_dlw, m_lw, m_dlg, m_lg, m_lt, m_dlt;
  logic signed [65:0] pa_w_c, pb_w_c, pa_g_c, pb_g_c;
  logic signed [63:0] r3_pa_w_q, r3_pb_w_q, r3_pa_g_q, r3_pb_g_q;
  logic [61:0] r3_lt2_q;
  side_t       r3_q;

  always_comb begin
    m_dlw  = $signed({2'b00, r2_q.dlw});
    m_lw   = $signed({2'b00, r2_q.lw});
    m_lg   = $signed({2'b00, r2_q.lg});
    m_lt   = $signed({2'b00, r2_q.lt});
    m_dlg  = $signed({r2_q.dlg[31], r2_q.dlg});
    m_dlt  = $signed({r2_q.dlt[31], r2_q.dlt});
    pa_w_c = m_dlw * m_lt;
    pb_w_c = m_lw * m_dlt;
    pa_g_c = m_dlg * m_lt;
    pb_g_c = m_lg * m_dlt;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      r3_pa_w_q <= pa_w_c[63:0];
      r3_pb_w_q <= pb_w_c[63:0];
      r3_pa_g_q <= pa_g_c[63:0];
      r3_pb_g_q <= pb_g_c[63:0];
      r3_lt2_q  <= r2_q.lt * r2_q.lt;
      r3_q      <= r2_q;
    end
  end

  // R4: numerators to sign and magnitude
  logic signed [63:0] num_w, num_g;
  logic [63:0] r4_mag_w_q, r4_mag_g_q;
  logic [61:0] r4_lt2_q;
  side_t       r4_side_d, r4_q;

  assign num_w = r3_pa_w_q - r3_pb_w_q;
  assign num_g = r3_pa_g_q - r3_pb_g_q;

  always_comb begin
    r4_side_d       = r3_q;
    r4_side_d.neg_w = num_w[63];
    r4_side_d.neg_g = num_g[63];
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      r4_mag_w_q <= num_w[63] ? (64'd0 - num_w) : num_w;
      r4_mag_g_q <= num_g[63] ? (64'd0 - num_g) : num_g;
      r4_lt2_q   <= r3_lt2_q;
      r4_q       <= r4_side_d;
    end
  end

  // R5: fraction divider setup. Lanes: 0 fw, 1 dfw, 2 fg, 3 dfg.
  // Fractions divide x*2^15 by lt; slopes divide |num|*2^16 by lt^2.
  rff_pkg::div_t r5_div_d [rff_pkg::LANES];
  rff_pkg::div_t r5_div_q [rff_pkg::LANES];
  side_t         r5_side_d, r5_q;

  always_comb begin
    r5_div_d[0].rem = {50'd0, r4_q.lw[30:17]};
    r5_div_d[0].lo  = {r4_q.lw[16:0], 15'd0};
    r5_div_d[0].den = {33'd0, r4_q.lt};
    r5_div_d[2].rem = {50'd0, r4_q.lg[30:17]};
    r5_div_d[2].lo  = {r4_q.lg[16:0], 15'd0};
    r5_div_d[2].den = {33'd0, r4_q.lt};
    r5_div_d[1].rem = {16'd0, r4_mag_w_q[63:16]};
    r5_div_d[1].lo  = {r4_mag_w_q[15:0], 16'd0};
    r5_div_d[1].den = {2'd0, r4_lt2_q};
    r5_div_d[3].rem = {16'd0, r4_mag_g_q[63:16]};
    r5_div_d[3].lo  = {r4_mag_g_q[15:0], 16'd0};
    r5_div_d[3].den = {2'd0, r4_lt2_q};
    for (int l = 0; l < rff_pkg::LANES; l++) begin
      r5_div_d[l].quo = '0;
    end
    r5_side_d       = r4_q;
    r5_side_d.ovf_w = (r5_div_d[1].rem >= r5_div_d[1].den);
    r5_side_d.ovf_g = (r5_div_d[3].rem >= r5_div_d[3].den);
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      r5_div_q <= r5_div_d;
      r5_q     <= r5_side_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Fraction divider row
  // ---------------------------------------------------------------------------
  rff_pkg::div_t fc [rff_pkg::LANES][rff_pkg::DIV_STEPS+1];
  side_t fside_q [rff_pkg::DIV_STEPS];

  for (genvar l = 0; l < rff_pkg::LANES; l++) begin : g_flane
    assign fc[l][0] = r5_div_q[l];
    for (genvar k = 0; k < rff_pkg::DIV_STEPS; k++) begin : g_fcell
      rff_div_cell u_cell (
        .clk_i (clk_i),
        .en_i  (pipe_en),
        .d_i   (fc[l][k]),
        .d_o   (fc[l][k+1])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      fside_q[0] <= r5_q;
      for (int k = 1; k < rff_pkg::DIV_STEPS; k++) begin
        fside_q[k] <= fside_q[k-1];
      end
    end
  end

  // Final: round, saturate slopes to signed 32 bits, pick status.
  // Returns {saturated, value}.
  function automatic logic [32:0] slope_fix(input logic [32:0] q, input logic ovf,
                                            input logic neg);
    logic        sat;
    logic [31:0] mag;
    if (neg) begin
      sat = ovf || (q > rff_pkg::MIN32_MAG_W33);
      mag = sat ? rff_pkg::MIN32_MAG : q[31:0];
      return {sat, 32'd0 - mag};
    end
    sat = ovf || (q > rff_pkg::MAX31_W33);
    return {sat, sat ? {1'b0, rff_pkg::MAX31} : q[31:0]};
  endfunction

  side_t       fs;
  logic [32:0] fq [rff_pkg::LANES];
  logic [32:0] dfw_c, dfg_c;
  res_t        res_c;

  always_comb begin
    fs = fside_q[rff_pkg::DIV_STEPS-1];
    for (int l = 0; l < rff_pkg::LANES; l++) begin
      fq[l] = rff_pkg::div_round(fc[l][rff_pkg::DIV_STEPS]);
    end
    dfw_c = slope_fix(fq[1], fs.ovf_w, fs.neg_w);
    dfg_c = slope_fix(fq[3], fs.ovf_g, fs.neg_g);

    res_c.lw  = fs.lw;
    res_c.dlw = fs.dlw;
    res_c.lg  = fs.lg;
    res_c.dlg = fs.dlg;
    res_c.lt  = fs.lt;
    res_c.dlt = fs.dlt;
    if (fs.lt == '0) begin
      // zero total mobility: no fractions
      res_c.fw     = '0;
      res_c.dfw    = '0;
      res_c.fg     = '0;
      res_c.dfg    = '0;
      res_c.status = rff_pkg::STATUS_ZERO_TOTAL;
    end else begin
      res_c.fw     = fq[0][15:0];
      res_c.dfw    = dfw_c[31:0];
      res_c.fg     = fq[2][15:0];
      res_c.dfg    = dfg_c[31:0];
      res_c.status = (fs.flag || dfw_c[32] || dfg_c[32]) ? rff_pkg::STATUS_SATURATED
                                                          : rff_pkg::STATUS_OK;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register plus skid entry
  // ---------------------------------------------------------------------------
  res_t out_q, skid_q;
  logic push, take;

  assign push = pipe_en && vld_q[rff_pkg::PIPE_DEPTH-1];
  assign take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (take) begin
          skid_valid_q <= 1'b0;
        end
      end else if (push && out_valid_q && !take) begin
        skid_valid_q <= 1'b1;
      end
      out_valid_q <= push || skid_valid_q || (out_valid_q && !take);
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (!out_valid_q || take) begin
        out_q <= res_c;
      end else begin
        skid_q <= res_c;
      end
    end
  end

  assign out_valid_o            = out_valid_q;
  assign water_mobility_o       = out_q.lw;
  assign water_mobility_slope_o = out_q.dlw;
  assign gas_mobility_o         = out_q.lg;
  assign gas_mobility_slope_o   = out_q.dlg;
  assign total_mobility_o       = out_q.lt;
  assign total_mobility_slope_o = out_q.dlt;
  assign water_fraction_o       = out_q.fw;
  assign water_fraction_slope_o = out_q.dfw;
  assign gas_fraction_o         = out_q.fg;
  assign gas_fraction_slope_o   = out_q.dfg;
  assign status_o               = out_q.status;

endmodule

>>> rtl/rff_checker.sv
// Port-level checks for the relative permeability / fractional flow unit, bound to the top.
module rff_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [30:0] water_mobility_o,
  input logic [30:0] water_mobility_slope_o,
  input logic [30:0] gas_mobility_o,
  input logic [31:0] gas_mobility_slope_o,
  input logic [30:0] total_mobility_o,
  input logic [31:0] total_mobility_slope_o,
  input logic [15:0] water_fraction_o,
  input logic [31:0] water_fraction_slope_o,
  input logic [15:0] gas_fraction_o,
  input logic [31:0] gas_fraction_slope_o,
  input logic [1:0]  status_o
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(water_fraction_o)
      && $stable(status_o) && $stable(total_mobility_o)
      && $stable(water_mobility_o) && $stable(gas_mobility_o))
    else $error("stalled output word changed");

  // zero total mobility yields zero fractions and slopes
  a_zero_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == rff_pkg::STATUS_ZERO_TOTAL) |->
      (water_fraction_o == '0) && (gas_fraction_o == '0)
      && (water_fraction_slope_o == '0) && (gas_fraction_slope_o == '0)
      && (total_mobility_o == '0))
    else $error("zero total mobility with nonzero fractions");

  // total slope is the sum of the phase slopes
  a_slope_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> total_mobility_slope_o == ({1'b0, water_mobility_slope_o}
      + gas_mobility_slope_o))
    else $error("total slope mismatch");

  // status never carries the unused code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == rff_pkg::STATUS_OK) || (status_o == rff_pkg::STATUS_ZERO_TOTAL)
      || (status_o == rff_pkg::STATUS_SATURATED))
    else $error("illegal status code");

endmodule

bind relperm_fractional_flow_unit rff_checker u_rff_checker (.*);
